@@ design/lfsc_pkg.sv @@
// Shared types and constants of the LED frame slot compositor.
// Holds slot, colour and stream layout constants and the lane control struct.
// No dependencies.
package lfsc_pkg;

    localparam int SLOT_COUNT = 4;
    localparam int SLOT_W     = 2;
    localparam int ID_W       = 32;
    localparam int STAMP_W    = 32;
    localparam int CHAN_W     = 8;
    localparam int COLOUR_W   = 3 * CHAN_W;
    localparam int BULB_IDX_W = 6;

    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hff;

    localparam logic OP_HEADER = 1'b0;
    localparam logic OP_BULB   = 1'b1;

    localparam int S_TDATA_W = 96;
    localparam int M_TDATA_W = 32;

    localparam int S_CLEAR_POS = 0;
    localparam int S_ID_LSB    = 1;
    localparam int S_NOW_LSB   = S_ID_LSB + ID_W;
    localparam int S_RED_LSB   = S_NOW_LSB + STAMP_W;
    localparam int S_GREEN_LSB = S_RED_LSB + CHAN_W;
    localparam int S_BLUE_LSB  = S_GREEN_LSB + CHAN_W;

    typedef struct packed {
        logic                clear;
        logic                hdr_we;
        logic                rd_en;
        logic                wr_en;
        logic [ID_W-1:0]     id;
        logic [STAMP_W-1:0]  stamp;
        logic [COLOUR_W-1:0] colour;
    } lfsc_lane_ctrl_t;

endpackage

@@ design/lfsc_lane.sv @@
// One frame slot: sender id, timestamp and a per-bulb colour memory with valid bits.
// Depends on lfsc_pkg.
module lfsc_lane
    import lfsc_pkg::*;
#(
    parameter int DEPTH  = 50,
    parameter int ADDR_W = 6
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  lfsc_lane_ctrl_t       ctrl,
    input  logic [ADDR_W-1:0]     addr,
    output logic [ID_W-1:0]       sender,
    output logic [STAMP_W-1:0]    stamp,
    output logic [COLOUR_W-1:0]   rd_colour
);

    logic [COLOUR_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]    valid_reg;
    logic [ID_W-1:0]     sender_reg;
    logic [STAMP_W-1:0]  stamp_reg;
    logic [COLOUR_W-1:0] rd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            sender_reg <= '0;
            stamp_reg  <= '0;
        end else if (ctrl.clear) begin
            valid_reg  <= '0;
            sender_reg <= '0;
            stamp_reg  <= '0;
        end else begin
            if (ctrl.hdr_we) begin
                sender_reg <= ctrl.id;
                stamp_reg  <= ctrl.stamp;
            end
            if (ctrl.wr_en) begin
                valid_reg[addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.wr_en) begin
            mem[addr] <= ctrl.colour;
        end
        if (ctrl.rd_en) begin
            if (ctrl.wr_en) begin
                rd_reg <= ctrl.colour;
            end else if (valid_reg[addr]) begin
                rd_reg <= mem[addr];
            end else begin
                rd_reg <= '0;
            end
        end
    end

    assign sender    = sender_reg;
    assign stamp     = stamp_reg;
    assign rd_colour = rd_reg;

endmodule

@@ design/lfsc_merge.sv @@
// Merging stage: per-channel sum of the slot colours, saturated at full scale.
// Depends on lfsc_pkg.
module lfsc_merge
    import lfsc_pkg::*;
(
    input  logic [SLOT_COUNT-1:0][COLOUR_W-1:0] colours,
    output logic [COLOUR_W-1:0]                 mixed
);

    always_comb begin
        logic [CHAN_W+SLOT_W-1:0] acc;
        mixed = '0;
        for (int c = 0; c < 3; c++) begin
            acc = '0;
            for (int s = 0; s < SLOT_COUNT; s++) begin
                acc = acc + {{SLOT_W{1'b0}}, colours[s][c*CHAN_W +: CHAN_W]};
            end
            if (acc > {{SLOT_W{1'b0}}, CHAN_MAX}) begin
                mixed[c*CHAN_W +: CHAN_W] = CHAN_MAX;
            end else begin
                mixed[c*CHAN_W +: CHAN_W] = acc[CHAN_W-1:0];
            end
        end
    end

endmodule

@@ design/led_frame_slot_compositor.sv @@
// Top level of the LED frame slot compositor: control sequencer, slot picker,
// four slot lanes and the merging stage. Depends on lfsc_pkg, lfsc_lane, lfsc_merge.
//
// Usage: items enter on the s_ stream. s_tuser is the operation (0 header,
// 1 bulb colour). A header may clear every slot, then picks the slot whose
// sender id matches or else the oldest slot, stamps it and opens a frame of
// BULB_COUNT bulbs. Each bulb transaction stores its colour in that slot and
// yields one result on the m_ stream: the bulb index and the saturated
// per-channel sum over all four slots, with m_tlast on the final bulb.
// Bulbs outside an open frame are dropped without a result.
// Timing: a header has an accept step, then a slot pick over the four
// id and timestamp registers. A bulb has an accept step with the lane
// memory read, then the merge sum into the output register. A dropped
// bulb ends with its accept step.
// The output register lets the next item be accepted while a result waits;
// a stalled receiver holds the sequencer in its merge step until it frees.
// Reset: synchronous, active low; it clears ids, stamps and the colour valid
// bits at once, so no clearing pass is needed, and closes any frame.
module led_frame_slot_compositor
    import lfsc_pkg::*;
#(
    parameter int BULB_COUNT = 50
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // clear_all, sender_id, now_seconds, red_in, green_in, blue_in
    input  logic [S_TDATA_W-1:0] s_tdata,
    // operation
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // bulb_index, red_out, green_out, blue_out
    output logic [M_TDATA_W-1:0] m_tdata,
    // last_bulb
    output logic                 m_tlast
);

    localparam int ADDR_W = (BULB_COUNT > 1) ? $clog2(BULB_COUNT) : 1;
    localparam logic [BULB_IDX_W-1:0] LAST_BULB = BULB_IDX_W'(BULB_COUNT - 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_PICK = 3'b010,
        ST_MIX  = 3'b100
    } state_t;

    state_t                  state_reg, state_next;
    logic                    frame_open_reg;
    logic [BULB_IDX_W-1:0]   counter_reg;
    logic [SLOT_W-1:0]       target_reg;
    logic [ID_W-1:0]         id_cap_reg;
    logic [STAMP_W-1:0]      stamp_cap_reg;
    logic                    m_valid_reg;
    logic [M_TDATA_W-1:0]    m_data_reg;
    logic                    m_last_reg;

    logic                    s_acc, hdr_acc, bulb_acc, out_free, out_load;
    logic [SLOT_W-1:0]       pick;
    logic [SLOT_W-1:0]       best01, best23;
    logic [SLOT_COUNT-1:0]   id_hit;
    lfsc_lane_ctrl_t         ctrl [SLOT_COUNT];
    logic [ID_W-1:0]         senders [SLOT_COUNT];
    logic [STAMP_W-1:0]      stamps [SLOT_COUNT];
    logic [SLOT_COUNT-1:0][COLOUR_W-1:0] colours;
    logic [COLOUR_W-1:0]     mixed;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign hdr_acc  = s_acc && (s_tuser == OP_HEADER);
    assign bulb_acc = s_acc && (s_tuser == OP_BULB) && frame_open_reg;
    assign out_free = !m_valid_reg || m_tready;
    assign out_load = (state_reg == ST_MIX) && out_free;

    always_comb begin
        for (int s = 0; s < SLOT_COUNT; s++) begin
            id_hit[s] = (senders[s] == id_cap_reg);
        end
        best01 = (stamps[1] < stamps[0]) ? 2'd1 : 2'd0;
        best23 = (stamps[3] < stamps[2]) ? 2'd3 : 2'd2;
        if (id_hit[0]) begin
            pick = 2'd0;
        end else if (id_hit[1]) begin
            pick = 2'd1;
        end else if (id_hit[2]) begin
            pick = 2'd2;
        end else if (id_hit[3]) begin
            pick = 2'd3;
        end else if (stamps[best23] < stamps[best01]) begin
            pick = best23;
        end else begin
            pick = best01;
        end
    end

    always_comb begin
        for (int s = 0; s < SLOT_COUNT; s++) begin
            ctrl[s].clear  = hdr_acc && s_tdata[S_CLEAR_POS];
            ctrl[s].hdr_we = (state_reg == ST_PICK) && (pick == SLOT_W'(s));
            ctrl[s].rd_en  = bulb_acc;
            ctrl[s].wr_en  = bulb_acc && (target_reg == SLOT_W'(s));
            ctrl[s].id     = id_cap_reg;
            ctrl[s].stamp  = stamp_cap_reg;
            ctrl[s].colour = {s_tdata[S_RED_LSB +: CHAN_W], s_tdata[S_GREEN_LSB +: CHAN_W],
                              s_tdata[S_BLUE_LSB +: CHAN_W]};
        end
    end

    for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_lane
        lfsc_lane #(
            .DEPTH  (BULB_COUNT),
            .ADDR_W (ADDR_W)
        ) u_lane (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl[g]),
            .addr      (counter_reg[ADDR_W-1:0]),
            .sender    (senders[g]),
            .stamp     (stamps[g]),
            .rd_colour (colours[g])
        );
    end

    lfsc_merge u_merge (
        .colours (colours),
        .mixed   (mixed)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (hdr_acc) begin
                    state_next = ST_PICK;
                end else if (bulb_acc) begin
                    state_next = ST_MIX;
                end
            end
            ST_PICK: begin
                state_next = ST_IDLE;
            end
            ST_MIX: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            frame_open_reg <= 1'b0;
            counter_reg    <= '0;
            target_reg     <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (hdr_acc) begin
                frame_open_reg <= 1'b1;
                counter_reg    <= '0;
            end
            if (state_reg == ST_PICK) begin
                target_reg <= pick;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
                if (counter_reg == LAST_BULB) begin
                    frame_open_reg <= 1'b0;
                    counter_reg    <= '0;
                end else begin
                    counter_reg <= counter_reg + 1'b1;
                end
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (hdr_acc) begin
            id_cap_reg    <= s_tdata[S_ID_LSB +: ID_W];
            stamp_cap_reg <= s_tdata[S_NOW_LSB +: STAMP_W];
        end
        if (out_load) begin
            m_data_reg <= {2'b00, mixed[CHAN_W-1:0], mixed[2*CHAN_W-1:CHAN_W],
                           mixed[3*CHAN_W-1:2*CHAN_W], counter_reg};
            m_last_reg <= (counter_reg == LAST_BULB);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    a_pick_one_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PICK) |=> (state_reg == ST_IDLE))
        else $error("slot pick did not return to idle");

    a_mix_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MIX) |-> (frame_open_reg && ({1'b0, counter_reg} < 7'(BULB_COUNT))))
        else $error("merge step outside an open frame");

    a_last_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && (counter_reg == LAST_BULB)) |=> (!frame_open_reg && m_tlast && m_tvalid))
        else $error("final bulb did not close the frame");

endmodule
